>>> hw/rtl/ssp_pkg.sv
package ssp_pkg;

	localparam int CELL_BITS = 12;
	localparam int CELLS     = 4096;
	localparam int CNT_W     = 13;
	localparam int WORD_BITS = 64;
	localparam int FILL_W    = 7;
	localparam int MIN_BITS  = 4;
	localparam int IDX_W     = 13;

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_FETCH = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic KIND_PAL  = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BRD,
		ST_BGOT,
		ST_SRD,
		ST_SCMP,
		ST_BFIN,
		ST_PRD,
		ST_POUT,
		ST_WCHK,
		ST_WADD
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PAL,
		PH_WORDS
	} phase_t;

endpackage

>>> hw/rtl/ssp_ram.sv
module ssp_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/ssp_pack.sv
module ssp_pack (
	input  logic [ssp_pkg::WORD_BITS-1:0] acc,
	input  logic [ssp_pkg::FILL_W-1:0]    fill,
	input  logic [ssp_pkg::CELL_BITS-1:0] v,
	input  logic [3:0]                    bits,
	output logic [ssp_pkg::WORD_BITS-1:0] acc_n,
	output logic [ssp_pkg::FILL_W-1:0]    fill_n,
	output logic [ssp_pkg::CELL_BITS-1:0] carry,
	output logic [3:0]                    carry_fill
);

	logic [ssp_pkg::FILL_W-1:0] room;

	always_comb begin
		room  = ssp_pkg::FILL_W'(ssp_pkg::WORD_BITS) - fill;
		// Bits of v above the room fall off the top of the shift.
		acc_n = acc | (ssp_pkg::WORD_BITS'(v) << fill[5:0]);
		if (ssp_pkg::FILL_W'(bits) <= room) begin
			fill_n     = fill + ssp_pkg::FILL_W'(bits);
			carry      = '0;
			carry_fill = '0;
		end else begin
			fill_n     = ssp_pkg::FILL_W'(ssp_pkg::WORD_BITS);
			carry      = v >> room[3:0];
			carry_fill = bits - room[3:0];
		end
	end

endmodule

>>> hw/rtl/section_palette_packer.sv
// Set and command 3 leave the block idle. Clear sweeps the cell memory with busy high.
// A fetch that starts a run builds the palette (read and check states per cell, read and
// compare states per palette compare, linear search shared by all cells), then returns the
// first entry; later fetches return an entry or a word (one index RAM read per cell).
// Commands are taken one at a time; the receiver cannot stall, results last one cycle.
// Reset: asynchronous, a sweep clears the cube with busy high.
module section_palette_packer #(
	parameter int CODE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] block_code,
	input  logic [3:0]  pos_x,
	input  logic [3:0]  pos_y,
	input  logic [3:0]  pos_z,
	output logic        strobe,
	output logic        kind,
	output logic [63:0] value,
	output logic [3:0]  entry_bits,
	output logic        last_of_run
);

	localparam int CB = ssp_pkg::CELL_BITS;

	ssp_pkg::state_t state_q, state_d;
	ssp_pkg::phase_t phase_q;

	logic [CB-1:0]                 i_q, k_q, last_idx_q;
	logic [ssp_pkg::CNT_W-1:0]     count_q, nonair_q, cursor_q;
	logic                          any_empty_q, last_hit_q;
	logic [CODE_WIDTH-1:0]         code_q, last_code_q;
	logic [ssp_pkg::WORD_BITS-1:0] acc_q;
	logic [ssp_pkg::FILL_W-1:0]    fill_q;
	logic [CB-1:0]                 carry_q;
	logic [3:0]                    cfill_q, bits_q;

	logic                  accept;
	logic                  cell_we, pal_we, idx_we;
	logic [CB-1:0]         cell_waddr, cell_raddr, pal_waddr, pal_raddr, idx_waddr, idx_raddr;
	logic [CODE_WIDTH-1:0] cell_wdata, cell_rd, pal_wdata, pal_rd, code_in;
	logic [ssp_pkg::IDX_W-1:0] idx_wdata, idx_rd;

	logic [3:0]                    need, run_bits;
	logic [CB-1:0]                 v;
	logic [ssp_pkg::WORD_BITS-1:0] acc_n;
	logic [ssp_pkg::FILL_W-1:0]    fill_n;
	logic [CB-1:0]                 carry_n;
	logic [3:0]                    cfill_n;
	logic                          word_last;

	assign accept  = start && !busy;
	assign busy    = (state_q != ssp_pkg::ST_IDLE);
	assign code_in = CODE_WIDTH'(block_code);

	ssp_ram #(.ADDR_W(CB), .DATA_W(CODE_WIDTH)) u_cell (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.raddr(cell_raddr), .rdata(cell_rd)
	);

	ssp_ram #(.ADDR_W(CB), .DATA_W(CODE_WIDTH)) u_pal (
		.clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
		.raddr(pal_raddr), .rdata(pal_rd)
	);

	ssp_ram #(.ADDR_W(CB), .DATA_W(ssp_pkg::IDX_W)) u_idx (
		.clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
		.raddr(idx_raddr), .rdata(idx_rd)
	);

	// Empty cells are stored with a flag; their index is the count of distinct nonzero codes.
	assign v = idx_rd[CB] ? nonair_q[CB-1:0] : idx_rd[CB-1:0];

	ssp_pack u_pack (
		.acc(acc_q), .fill(fill_q), .v(v), .bits(bits_q),
		.acc_n(acc_n), .fill_n(fill_n), .carry(carry_n), .carry_fill(cfill_n)
	);

	always_comb begin
		need = 4'(CB);
		for (int n = CB; n >= 0; n--) begin
			if ((ssp_pkg::CNT_W'(1) << n) >= count_q) begin
				need = 4'(n);
			end
		end
		run_bits = (need < 4'(ssp_pkg::MIN_BITS)) ? 4'(ssp_pkg::MIN_BITS) : need;
	end

	assign word_last = cursor_q[CB] && (cfill_q == 4'd0);

	always_comb begin
		state_d    = state_q;
		cell_we    = 1'b0;
		cell_waddr = i_q;
		cell_wdata = '0;
		cell_raddr = i_q;
		pal_we     = 1'b0;
		pal_waddr  = count_q[CB-1:0];
		pal_wdata  = code_q;
		pal_raddr  = k_q;
		idx_we     = 1'b0;
		idx_waddr  = i_q;
		idx_wdata  = '0;
		idx_raddr  = cursor_q[CB-1:0];
		unique case (state_q)
			ssp_pkg::ST_CLEAR: begin
				cell_we = 1'b1;
				if (i_q == '1) begin
					state_d = ssp_pkg::ST_IDLE;
				end
			end
			ssp_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (command)
						ssp_pkg::CMD_SET: begin
							cell_we    = 1'b1;
							cell_waddr = {pos_y, pos_z, pos_x};
							cell_wdata = code_in;
						end
						ssp_pkg::CMD_CLEAR: state_d = ssp_pkg::ST_CLEAR;
						ssp_pkg::CMD_FETCH: begin
							unique case (phase_q)
								ssp_pkg::PH_PAL:   state_d = ssp_pkg::ST_PRD;
								ssp_pkg::PH_WORDS: state_d = ssp_pkg::ST_WCHK;
								default:           state_d = ssp_pkg::ST_BRD;
							endcase
						end
						default: ;
					endcase
				end
			end
			ssp_pkg::ST_BRD: state_d = ssp_pkg::ST_BGOT;
			ssp_pkg::ST_BGOT: begin
				if (cell_rd == '0) begin
					idx_we    = 1'b1;
					idx_wdata = {1'b1, {CB{1'b0}}};
					state_d   = (i_q == '1) ? ssp_pkg::ST_BFIN : ssp_pkg::ST_BRD;
				end else if (last_hit_q && cell_rd == last_code_q) begin
					idx_we    = 1'b1;
					idx_wdata = {1'b0, last_idx_q};
					state_d   = (i_q == '1) ? ssp_pkg::ST_BFIN : ssp_pkg::ST_BRD;
				end else if (count_q == '0) begin
					pal_we    = 1'b1;
					pal_wdata = cell_rd;
					idx_we    = 1'b1;
					idx_wdata = {1'b0, count_q[CB-1:0]};
					state_d   = (i_q == '1) ? ssp_pkg::ST_BFIN : ssp_pkg::ST_BRD;
				end else begin
					state_d = ssp_pkg::ST_SRD;
				end
			end
			ssp_pkg::ST_SRD: state_d = ssp_pkg::ST_SCMP;
			ssp_pkg::ST_SCMP: begin
				if (pal_rd == code_q) begin
					idx_we    = 1'b1;
					idx_wdata = {1'b0, k_q};
					state_d   = (i_q == '1) ? ssp_pkg::ST_BFIN : ssp_pkg::ST_BRD;
				end else if (ssp_pkg::CNT_W'(k_q) + 1'b1 == count_q) begin
					pal_we    = 1'b1;
					idx_we    = 1'b1;
					idx_wdata = {1'b0, count_q[CB-1:0]};
					state_d   = (i_q == '1) ? ssp_pkg::ST_BFIN : ssp_pkg::ST_BRD;
				end else begin
					state_d = ssp_pkg::ST_SRD;
				end
			end
			ssp_pkg::ST_BFIN: begin
				pal_we    = any_empty_q;
				pal_wdata = '0;
				state_d   = ssp_pkg::ST_PRD;
			end
			ssp_pkg::ST_PRD: begin
				pal_raddr = cursor_q[CB-1:0];
				state_d   = ssp_pkg::ST_POUT;
			end
			ssp_pkg::ST_POUT: state_d = ssp_pkg::ST_IDLE;
			ssp_pkg::ST_WCHK: begin
				if (fill_q < ssp_pkg::FILL_W'(ssp_pkg::WORD_BITS) && !cursor_q[CB]) begin
					state_d = ssp_pkg::ST_WADD;
				end else begin
					state_d = ssp_pkg::ST_IDLE;
				end
			end
			ssp_pkg::ST_WADD: state_d = ssp_pkg::ST_WCHK;
			default: state_d = ssp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ssp_pkg::PH_IDLE;
			i_q         <= '0;
			k_q         <= '0;
			count_q     <= '0;
			nonair_q    <= '0;
			cursor_q    <= '0;
			any_empty_q <= 1'b0;
			last_hit_q  <= 1'b0;
			code_q      <= '0;
			last_code_q <= '0;
			last_idx_q  <= '0;
			acc_q       <= '0;
			fill_q      <= '0;
			carry_q     <= '0;
			cfill_q     <= '0;
			bits_q      <= 4'(ssp_pkg::MIN_BITS);
			strobe      <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ssp_pkg::ST_CLEAR: i_q <= i_q + 1'b1;
				ssp_pkg::ST_IDLE: begin
					if (accept) begin
						if (command == ssp_pkg::CMD_SET || command == ssp_pkg::CMD_CLEAR) begin
							phase_q  <= ssp_pkg::PH_IDLE;
							cursor_q <= '0;
							acc_q    <= '0;
							fill_q   <= '0;
							carry_q  <= '0;
							cfill_q  <= '0;
							i_q      <= '0;
						end else if (command == ssp_pkg::CMD_FETCH &&
							     phase_q == ssp_pkg::PH_IDLE) begin
							i_q         <= '0;
							count_q     <= '0;
							any_empty_q <= 1'b0;
							last_hit_q  <= 1'b0;
						end
					end
				end
				ssp_pkg::ST_BGOT: begin
					code_q <= cell_rd;
					k_q    <= '0;
					if (cell_rd == '0) begin
						any_empty_q <= 1'b1;
						i_q         <= i_q + 1'b1;
					end else if (last_hit_q && cell_rd == last_code_q) begin
						i_q <= i_q + 1'b1;
					end else if (count_q == '0) begin
						count_q     <= count_q + 1'b1;
						last_hit_q  <= 1'b1;
						last_code_q <= cell_rd;
						last_idx_q  <= count_q[CB-1:0];
						i_q         <= i_q + 1'b1;
					end
				end
				ssp_pkg::ST_SCMP: begin
					if (pal_rd == code_q) begin
						last_hit_q  <= 1'b1;
						last_code_q <= code_q;
						last_idx_q  <= k_q;
						i_q         <= i_q + 1'b1;
					end else if (ssp_pkg::CNT_W'(k_q) + 1'b1 == count_q) begin
						count_q     <= count_q + 1'b1;
						last_hit_q  <= 1'b1;
						last_code_q <= code_q;
						last_idx_q  <= count_q[CB-1:0];
						i_q         <= i_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ssp_pkg::ST_BFIN: begin
					nonair_q <= count_q;
					if (any_empty_q) begin
						count_q <= count_q + 1'b1;
					end
					phase_q  <= ssp_pkg::PH_PAL;
					cursor_q <= '0;
					acc_q    <= '0;
					fill_q   <= '0;
					carry_q  <= '0;
					cfill_q  <= '0;
				end
				ssp_pkg::ST_PRD: bits_q <= run_bits;
				ssp_pkg::ST_POUT: begin
					strobe <= 1'b1;
					if (cursor_q + 1'b1 >= count_q) begin
						phase_q  <= ssp_pkg::PH_WORDS;
						cursor_q <= '0;
					end else begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
				ssp_pkg::ST_WCHK: begin
					if (fill_q < ssp_pkg::FILL_W'(ssp_pkg::WORD_BITS) && !cursor_q[CB]) begin
						cursor_q <= cursor_q + 1'b1;
					end else begin
						strobe  <= 1'b1;
						acc_q   <= ssp_pkg::WORD_BITS'(carry_q);
						fill_q  <= ssp_pkg::FILL_W'(cfill_q);
						carry_q <= '0;
						cfill_q <= '0;
						if (word_last) begin
							phase_q  <= ssp_pkg::PH_IDLE;
							cursor_q <= '0;
							acc_q    <= '0;
							fill_q   <= '0;
						end
					end
				end
				ssp_pkg::ST_WADD: begin
					acc_q   <= acc_n;
					fill_q  <= fill_n;
					carry_q <= carry_n;
					cfill_q <= cfill_n;
				end
				default: ;
			endcase
		end
	end

	// Result fields are loaded on the cycle that raises the strobe.
	always_ff @(posedge clk) begin
		if (state_q == ssp_pkg::ST_POUT) begin
			kind        <= ssp_pkg::KIND_PAL;
			value       <= 64'(pal_rd);
			entry_bits  <= bits_q;
			last_of_run <= 1'b0;
		end else if (state_q == ssp_pkg::ST_WCHK) begin
			kind        <= ssp_pkg::KIND_WORD;
			value       <= acc_q;
			entry_bits  <= bits_q;
			last_of_run <= word_last;
		end
	end

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("result beat while busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("back-to-back result beats");

	a_pal_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == ssp_pkg::KIND_PAL |-> !last_of_run)
		else $error("palette beat flagged last");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> entry_bits >= 4'd4 && entry_bits <= 4'd12)
		else $error("entry width out of range");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] code;
		logic [3:0]  x, y, z;
	} cmd_beat_t;

	typedef struct {
		logic        kind;
		logic [63:0] value;
		logic [3:0]  bits;
		logic        last;
	} fetch_res_t;

	localparam int IDLE_LIMIT = 3000000;
	// The one command code that the block ignores.
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [15:0] block_code;
	logic [3:0]  pos_x, pos_y, pos_z;
	logic        strobe;
	logic        kind;
	logic [63:0] value;
	logic [3:0]  entry_bits;
	logic        last_of_run;

	section_palette_packer u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .block_code(block_code),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.strobe(strobe), .kind(kind), .value(value),
		.entry_bits(entry_bits), .last_of_run(last_of_run)
	);

	cmd_beat_t  cmd_queue[$];
	fetch_res_t pending_results[$];

	// Shadow copy of the cube and of the current run.
	logic [15:0]     cube[ssp_pkg::CELLS];
	logic [15:0]     palette[ssp_pkg::CELLS];
	int              cell_pal_idx[ssp_pkg::CELLS];
	int              pal_size;
	ssp_pkg::phase_t run_phase;
	int              cursor;
	logic [63:0]     carry_word;
	int              carry_fill;
	int              run_bits;

	int errors, took_cnt, pal_seen, words_seen, runs_done, max_bits_seen;
	int quiet_cycles;
	logic took;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic add_cmd(logic [1:0] c, logic [15:0] code, logic [3:0] x, logic [3:0] y,
			logic [3:0] z);
		cmd_beat_t b;
		b.cmd = c; b.code = code; b.x = x; b.y = y; b.z = z;
		cmd_queue.insert(cmd_queue.size(), b);
	endtask

	task automatic add_fetches(int n);
		for (int i = 0; i < n; i++)
			add_cmd(ssp_pkg::CMD_FETCH, 16'($urandom), 4'($urandom), 4'($urandom),
				4'($urandom));
	endtask

	function automatic void build_palette_model();
		int seen[logic [15:0]];
		bit any_empty;
		int need;
		any_empty = 0;
		pal_size = 0;
		for (int i = 0; i < ssp_pkg::CELLS; i++) begin
			if (cube[i] == 16'd0) begin
				any_empty = 1;
			end else if (seen.exists(cube[i])) begin
				cell_pal_idx[i] = seen[cube[i]];
			end else begin
				seen[cube[i]] = pal_size;
				palette[pal_size] = cube[i];
				cell_pal_idx[i] = pal_size;
				pal_size++;
			end
		end
		if (any_empty || pal_size == 0) begin
			palette[pal_size] = 16'd0;
			for (int i = 0; i < ssp_pkg::CELLS; i++)
				if (cube[i] == 16'd0)
					cell_pal_idx[i] = pal_size;
			pal_size++;
		end
		need = 0;
		while ((1 << need) < pal_size)
			need++;
		run_bits = need < ssp_pkg::MIN_BITS ? ssp_pkg::MIN_BITS : need;
	endfunction

	function automatic void drop_run();
		run_phase = ssp_pkg::PH_IDLE;
		cursor = 0;
		carry_word = '0;
		carry_fill = 0;
	endfunction

	function automatic void predict_fetch(cmd_beat_t b);
		fetch_res_t r;
		logic [63:0] word, carry, v;
		int fill, cfill, room;
		if (b.cmd == ssp_pkg::CMD_SET) begin
			cube[{b.y, b.z, b.x}] = b.code;
			drop_run();
			return;
		end
		if (b.cmd == ssp_pkg::CMD_CLEAR) begin
			foreach (cube[i]) cube[i] = 16'd0;
			drop_run();
			return;
		end
		if (b.cmd != ssp_pkg::CMD_FETCH)
			return;
		if (run_phase == ssp_pkg::PH_IDLE) begin
			build_palette_model();
			drop_run();
			run_phase = ssp_pkg::PH_PAL;
		end
		r.bits = 4'(run_bits);
		if (run_phase == ssp_pkg::PH_PAL) begin
			r.kind = ssp_pkg::KIND_PAL;
			r.value = 64'(palette[cursor]);
			r.last = 1'b0;
			cursor++;
			if (cursor >= pal_size) begin
				run_phase = ssp_pkg::PH_WORDS;
				cursor = 0;
			end
		end else begin
			word = carry_word;
			fill = carry_fill;
			carry = '0;
			cfill = 0;
			while (fill < ssp_pkg::WORD_BITS && cursor < ssp_pkg::CELLS) begin
				v = 64'(cell_pal_idx[cursor]);
				room = ssp_pkg::WORD_BITS - fill;
				cursor++;
				if (run_bits <= room) begin
					word |= v << fill;
					fill += run_bits;
				end else begin
					word |= (v & ((64'd1 << room) - 64'd1)) << fill;
					carry = v >> room;
					cfill = run_bits - room;
					fill = ssp_pkg::WORD_BITS;
				end
			end
			carry_word = carry;
			carry_fill = cfill;
			r.kind = ssp_pkg::KIND_WORD;
			r.value = word;
			r.last = (cursor >= ssp_pkg::CELLS) && (cfill == 0);
			if (r.last)
				drop_run();
		end
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Monitor: results are checked before the beat accepted on the same edge is predicted.
	always @(posedge clk) begin
		fetch_res_t e;
		if (arst_n) begin
			took <= start && !busy;
			if (strobe) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result kind=%0d value=%h", kind, value);
				end else begin
					e = pending_results.pop_front();
					if (kind !== e.kind || value !== e.value || entry_bits !== e.bits
							|| last_of_run !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp k=%0d v=%h b=%0d l=%0d got k=%0d v=%h b=%0d l=%0d",
								e.kind, e.value, e.bits, e.last,
								kind, value, entry_bits, last_of_run);
					end
					if (e.kind == ssp_pkg::KIND_PAL) pal_seen++;
					else words_seen++;
					if (e.last) runs_done++;
					if (int'(e.bits) > max_bits_seen) max_bits_seen = e.bits;
				end
			end
			if (start && !busy) begin
				predict_fetch('{command, block_code, pos_x, pos_y, pos_z});
				took_cnt++;
			end
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired");
				$display("[section_palette_packer] ERROR");
				$finish;
			end
		end else begin
			took <= 1'b0;
		end
	end

	// Driver: bursts of random length separated by random gaps.
	int burst_left, gap_left;
	always @(negedge clk) begin
		cmd_beat_t b;
		if (arst_n && (!start || took)) begin
			if (took)
				void'(cmd_queue.pop_front());
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				b = cmd_queue[0];
				start <= 1'b1;
				command <= b.cmd;
				block_code <= b.code;
				pos_x <= b.x;
				pos_y <= b.y;
				pos_z <= b.z;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	initial begin
		logic [15:0] pool[$];
		int ncodes, nsets, sel;
		start = 1'b0; command = ssp_pkg::CMD_SET; block_code = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		arst_n = 1'b0;
		took = 1'b0;
		errors = 0; took_cnt = 0; pal_seen = 0; words_seen = 0;
		runs_done = 0; max_bits_seen = 0; quiet_cycles = 0;
		burst_left = 0; gap_left = 0;
		foreach (cube[i]) cube[i] = 16'd0;
		pal_size = 0;
		run_bits = ssp_pkg::MIN_BITS;
		drop_run();

		// Empty cube, corner cells with extreme codes, ignored command, set and clear mid-run.
		add_fetches(2);
		add_cmd(ssp_pkg::CMD_SET, 16'hFFFF, 4'hF, 4'hF, 4'hF);
		add_cmd(ssp_pkg::CMD_SET, 16'h0001, 4'h0, 4'h0, 4'h0);
		add_cmd(ssp_pkg::CMD_SET, 16'h8000, 4'hF, 4'h0, 4'hF);
		add_cmd(CMD_IGNORED, 16'h1234, 4'h5, 4'h6, 4'h7);
		add_fetches(5);
		add_cmd(ssp_pkg::CMD_SET, 16'h0000, 4'h0, 4'h0, 4'h0);
		add_fetches(3);
		add_cmd(ssp_pkg::CMD_CLEAR, 16'hFFFF, 4'hF, 4'hF, 4'hF);
		add_fetches(3);
		add_cmd(ssp_pkg::CMD_SET, 16'h7FFF, 4'h0, 4'hF, 4'h0);
		add_cmd(ssp_pkg::CMD_SET, 16'h7FFF, 4'h0, 4'hF, 4'h1);
		add_fetches(4);
		// A whole run on a nearly empty cube, crossing into the next run.
		add_fetches(270);

		// Random scenes: a small pool of codes scattered over the cube, then fetches.
		for (int ph = 0; cmd_queue.size() < 1550; ph++) begin
			if ($urandom_range(0, 2) == 0)
				add_cmd(ssp_pkg::CMD_CLEAR, 16'($urandom), 4'($urandom), 4'($urandom),
					4'($urandom));
			ncodes = (ph == 3) ? $urandom_range(33, 40) :
				(ph % 7 == 5) ? $urandom_range(17, 20) : $urandom_range(1, 5);
			pool.delete();
			for (int i = 0; i < ncodes; i++)
				pool.insert(pool.size(), 16'($urandom_range(1, 65535)));
			nsets = ncodes + $urandom_range(0, 25);
			for (int i = 0; i < nsets; i++) begin
				sel = (i < ncodes) ? i : $urandom_range(0, ncodes - 1);
				add_cmd(ssp_pkg::CMD_SET, ($urandom_range(0, 9) == 0) ? 16'd0 : pool[sel],
					4'($urandom), 4'($urandom), 4'($urandom));
			end
			if ($urandom_range(0, 4) == 0)
				add_cmd(CMD_IGNORED, 16'($urandom), 4'($urandom), 4'($urandom),
					4'($urandom));
			if (ph == 3 || $urandom_range(0, 3) == 0)
				add_fetches(ncodes + 1 + 64 * 6 + $urandom_range(0, 10));
			else
				add_fetches($urandom_range(1, 30));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() > 0 || start)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (5000) @(posedge clk);

		$display("%0d commands accepted, %0d palette entries and %0d packed words checked",
			took_cnt, pal_seen, words_seen);
		$display("%0d complete runs, widest index %0d bits", runs_done, max_bits_seen);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[section_palette_packer] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_results.size());
			$display("[section_palette_packer] ERROR");
		end
		$finish;
	end

endmodule
